FILE: rtl/hzr_pkg.sv
// Shared types and constants of the hierarchical z-buffer rasterizer.
package hzr_pkg;

  localparam logic signed [23:0] DEPTH_EMPTY = 24'sd8388607;
  localparam logic signed [23:0] DEPTH_LOW   = -24'sd8388608;
  localparam logic [12:0]        COUNT_MAX   = 13'd8191;
  localparam logic [3:0]         DIV_LAST    = 4'd15;
  localparam logic [1:0]         SUB_LAST    = 2'd3;

  localparam logic ACTION_DRAW = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef struct packed {
    logic load;
    logic setup;
    logic clear_step;
    logic rd_sel;
    logic tile_start;
    logic tile_adv;
    logic tile_write;
    logic acc_init;
    logic sub_clr;
    logic sub_inc;
    logic pix_start;
    logic edge_mul;
    logic edge_sum;
    logic old_cap;
    logic div_init;
    logic div_step;
    logic z_mul;
    logic z_sum;
    logic pix_write;
    logic acc_old;
    logic acc_new;
    logic out_draw;
    logic out_read;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bbox_empty;
    logic tile_skip;
    logic tile_last;
    logic sub_last;
    logic pix_in_frame;
    logic pix_test;
    logic div_last;
    logic z_less;
  } status_t;

endpackage

FILE: rtl/hzr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hzr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hzr_datapath.sv
// Datapath: stores, tile and pixel counters, edge evaluation, divider and depth blend.
module hzr_datapath #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [15:0]  vertex0_x,
  input  logic signed [15:0]  vertex0_y,
  input  logic signed [23:0]  vertex0_depth,
  input  logic signed [15:0]  vertex1_x,
  input  logic signed [15:0]  vertex1_y,
  input  logic signed [23:0]  vertex1_depth,
  input  logic signed [15:0]  vertex2_x,
  input  logic signed [15:0]  vertex2_y,
  input  logic signed [23:0]  vertex2_depth,
  input  logic [15:0]         triangle_tag,
  input  logic [11:0]         read_pixel,
  input  hzr_pkg::cmd_t       cmd,
  output hzr_pkg::status_t    status,
  output logic                result_kind,
  output logic [12:0]         pixels_written,
  output logic signed [23:0]  pixel_depth,
  output logic [15:0]         pixel_alpha,
  output logic [15:0]         pixel_beta,
  output logic [15:0]         pixel_triangle
);
  import hzr_pkg::*;

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int TC     = (FRAME_WIDTH + 1) / 2;
  localparam int TR     = (FRAME_HEIGHT + 1) / 2;
  localparam int TILES  = TC * TR;
  localparam int XW     = $clog2(FRAME_WIDTH);
  localparam int YW     = $clog2(FRAME_HEIGHT);
  localparam int AW     = $clog2(PIXELS);
  localparam int TAW    = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int CW     = (XW > YW) ? XW : YW;
  localparam int PW     = (CW + 10 > 18) ? CW + 10 : 18;
  localparam int PRW    = PW + 17;
  localparam int EW     = PRW + 3;
  localparam int RPW    = (AW > 12) ? AW : 12;

  // Latched transaction.
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic signed [23:0] vz [3];
  logic [15:0]        tag;
  logic [11:0]        rp;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx[0] <= vertex0_x; vy[0] <= vertex0_y; vz[0] <= vertex0_depth;
      vx[1] <= vertex1_x; vy[1] <= vertex1_y; vz[1] <= vertex1_depth;
      vx[2] <= vertex2_x; vy[2] <= vertex2_y; vz[2] <= vertex2_depth;
      tag   <= triangle_tag;
      rp    <= read_pixel;
    end
  end

  // Triangle setup: bounding box in pixels, least depth and edge vectors.
  logic signed [15:0] minx, maxx, miny, maxy;
  logic signed [23:0] minz_c;
  logic signed [16:0] minx_m1, miny_m1;
  logic signed [11:0] xlo_s, xhi_s, ylo_s, yhi_s, xlim, ylim, xlo_c, xhi_c, ylo_c, yhi_c;
  logic               empty_c;

  always_comb begin
    minx = vx[0]; maxx = vx[0]; miny = vy[0]; maxy = vy[0]; minz_c = vz[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
      if (vz[i] < minz_c) minz_c = vz[i];
    end
    minx_m1 = 17'(minx) - 17'sd1;
    miny_m1 = 17'(miny) - 17'sd1;
    xlo_s = 12'(minx_m1 >>> 8);
    ylo_s = 12'(miny_m1 >>> 8);
    xhi_s = 12'(maxx >>> 8);
    yhi_s = 12'(maxy >>> 8);
    xlim  = 12'(FRAME_WIDTH - 1);
    ylim  = 12'(FRAME_HEIGHT - 1);
    empty_c = (xhi_s < 0) || (xlo_s > xlim) || (xlo_s > xhi_s) ||
              (yhi_s < 0) || (ylo_s > ylim) || (ylo_s > yhi_s);
    xlo_c = (xlo_s < 0) ? 12'sd0 : xlo_s;
    ylo_c = (ylo_s < 0) ? 12'sd0 : ylo_s;
    xhi_c = (xhi_s > xlim) ? xlim : xhi_s;
    yhi_c = (yhi_s > ylim) ? ylim : yhi_s;
  end

  logic [XW-1:0]      xlo, xhi;
  logic [YW-1:0]      ylo, yhi;
  logic               bb_empty;
  logic signed [23:0] minz;
  logic signed [16:0] dvx [3];
  logic signed [16:0] dvy [3];

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      xlo      <= xlo_c[XW-1:0];
      xhi      <= xhi_c[XW-1:0];
      ylo      <= ylo_c[YW-1:0];
      yhi      <= yhi_c[YW-1:0];
      bb_empty <= empty_c;
      minz     <= minz_c;
      dvx[0]   <= 17'(vx[1]) - 17'(vx[2]);
      dvy[0]   <= 17'(vy[1]) - 17'(vy[2]);
      dvx[1]   <= 17'(vx[2]) - 17'(vx[0]);
      dvy[1]   <= 17'(vy[2]) - 17'(vy[0]);
      dvx[2]   <= 17'(vx[0]) - 17'(vx[1]);
      dvy[2]   <= 17'(vy[0]) - 17'(vy[1]);
    end
  end

  // Tile walk over the box, then the four pixels of each tile.
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  logic [1:0]    sub;
  logic [XW-1:0] txlo, txhi;
  logic [YW-1:0] tylo, tyhi;
  logic [XW:0]   x_full;
  logic [YW:0]   y_full;
  logic [TAW-1:0] tile_addr;

  assign txlo = xlo >> 1;
  assign txhi = xhi >> 1;
  assign tylo = ylo >> 1;
  assign tyhi = yhi >> 1;
  assign x_full = {tx, 1'b0} + (XW + 1)'(sub[0]);
  assign y_full = {ty, 1'b0} + (YW + 1)'(sub[1]);
  assign tile_addr = TAW'(ty) * TAW'(TC) + TAW'(tx);

  always_ff @(posedge clk) begin
    if (cmd.tile_start) begin
      tx <= txlo;
      ty <= tylo;
    end else if (cmd.tile_adv) begin
      if (tx == txhi) begin
        tx <= txlo;
        ty <= ty + YW'(1);
      end else begin
        tx <= tx + XW'(1);
      end
    end
    if (cmd.sub_clr) begin
      sub <= 2'd0;
    end else if (cmd.sub_inc) begin
      sub <= sub + 2'd1;
    end
  end

  // Pixel registers.
  logic [XW-1:0] pix_x;
  logic [YW-1:0] pix_y;
  logic [AW-1:0] pix_addr;
  logic          inbbox;

  always_ff @(posedge clk) begin
    if (cmd.pix_start) begin
      pix_x    <= x_full[XW-1:0];
      pix_y    <= y_full[YW-1:0];
      pix_addr <= AW'(y_full[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(x_full[XW-1:0]);
      inbbox   <= (x_full[XW-1:0] >= xlo) && (x_full[XW-1:0] <= xhi) &&
                  (y_full[YW-1:0] >= ylo) && (y_full[YW-1:0] <= yhi);
    end
  end

  // Edge functions at the pixel center, registered as products and then as their differences.
  logic signed [PW-1:0]  pxs, pys;
  logic signed [PW-1:0]  pdx [3];
  logic signed [PW-1:0]  pdy [3];
  logic signed [PRW-1:0] mx [3];
  logic signed [PRW-1:0] my [3];
  logic signed [EW-1:0]  e [3];
  logic signed [EW-1:0]  area;

  assign pxs = signed'(PW'({pix_x, 8'h80}));
  assign pys = signed'(PW'({pix_y, 8'h80}));
  // Edge 0 is anchored at vertex 2, edge 1 at vertex 0, edge 2 at vertex 1.
  assign pdx[0] = pxs - PW'(vx[2]);
  assign pdy[0] = pys - PW'(vy[2]);
  assign pdx[1] = pxs - PW'(vx[0]);
  assign pdy[1] = pys - PW'(vy[0]);
  assign pdx[2] = pxs - PW'(vx[1]);
  assign pdy[2] = pys - PW'(vy[1]);

  always_ff @(posedge clk) begin
    if (cmd.edge_mul) begin
      for (int i = 0; i < 3; i++) begin
        mx[i] <= dvx[i] * pdy[i];
        my[i] <= dvy[i] * pdx[i];
      end
    end
    if (cmd.edge_sum) begin
      for (int i = 0; i < 3; i++) begin
        e[i] <= EW'(mx[i]) - EW'(my[i]);
      end
      area <= (EW'(mx[0]) - EW'(my[0])) + (EW'(mx[1]) - EW'(my[1])) +
              (EW'(mx[2]) - EW'(my[2]));
    end
  end

  logic covered;
  assign covered = ((e[0] > 0) && (e[1] > 0) && (e[2] > 0)) ||
                   ((e[0] < 0) && (e[1] < 0) && (e[2] < 0));

  // Restoring divider, one quotient bit of each weight per cycle.
  logic [EW-1:0] den, ra, rb;
  logic [EW:0]   ra2, rb2;
  logic [15:0]   qa, qb;
  logic [3:0]    dcnt;
  logic          aneg;

  assign aneg = area < 0;
  assign ra2  = {ra, 1'b0};
  assign rb2  = {rb, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den  <= aneg ? unsigned'(-area) : unsigned'(area);
      ra   <= aneg ? unsigned'(-e[0]) : unsigned'(e[0]);
      rb   <= aneg ? unsigned'(-e[1]) : unsigned'(e[1]);
      dcnt <= 4'd0;
    end else if (cmd.div_step) begin
      if (ra2 >= {1'b0, den}) begin
        ra <= EW'(ra2 - {1'b0, den});
        qa <= {qa[14:0], 1'b1};
      end else begin
        ra <= EW'(ra2);
        qa <= {qa[14:0], 1'b0};
      end
      if (rb2 >= {1'b0, den}) begin
        rb <= EW'(rb2 - {1'b0, den});
        qb <= {qb[14:0], 1'b1};
      end else begin
        rb <= EW'(rb2);
        qb <= {qb[14:0], 1'b0};
      end
      dcnt <= dcnt + 4'd1;
    end
  end

  // Depth blend: products, then rounded sum.
  logic signed [17:0] gw;
  logic signed [41:0] zp [3];
  logic signed [43:0] zsum;
  logic signed [23:0] znew, old_depth, acc;
  logic [12:0]        count;

  assign gw   = 18'sd65536 - signed'({2'b00, qa}) - signed'({2'b00, qb});
  assign zsum = 44'(zp[0]) + 44'(zp[1]) + 44'(zp[2]) + 44'sd32768;

  logic signed [23:0] depth_rdata;
  logic signed [23:0] tile_rdata;

  always_ff @(posedge clk) begin
    if (cmd.z_mul) begin
      zp[0] <= signed'({1'b0, qa}) * vz[0];
      zp[1] <= signed'({1'b0, qb}) * vz[1];
      zp[2] <= gw * vz[2];
    end
    if (cmd.z_sum) begin
      znew <= zsum[39:16];
    end
    if (cmd.old_cap) begin
      old_depth <= depth_rdata;
    end
    if (cmd.acc_init) begin
      acc <= DEPTH_LOW;
    end else if (cmd.acc_new) begin
      if (znew > acc) acc <= znew;
    end else if (cmd.acc_old) begin
      if (old_depth > acc) acc <= old_depth;
    end
    if (cmd.setup) begin
      count <= 13'd0;
    end else if (cmd.pix_write && (count != COUNT_MAX)) begin
      count <= count + 13'd1;
    end
  end

  // Clearing pass counter after reset.
  logic [AW-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Stores.
  logic [RPW-1:0] rp_w;
  logic [AW-1:0]  raddr, waddr;
  logic           swe, twe, rp_in_range;
  logic [TAW-1:0] twaddr;
  logic [23:0]    dwdata, twdata, drd, trd;
  logic [15:0]    awdata, bwdata, iwdata, ard, brd, ird;

  assign rp_w        = RPW'(rp);
  assign rp_in_range = (RPW + 1)'(rp) < (RPW + 1)'(PIXELS);
  assign raddr  = cmd.rd_sel ? rp_w[AW-1:0] : pix_addr;
  assign swe    = cmd.clear_step || cmd.pix_write;
  assign waddr  = cmd.clear_step ? clr_cnt : pix_addr;
  assign dwdata = cmd.clear_step ? DEPTH_EMPTY : znew;
  assign awdata = cmd.clear_step ? 16'd0 : qa;
  assign bwdata = cmd.clear_step ? 16'd0 : qb;
  assign iwdata = cmd.clear_step ? 16'd0 : tag;
  assign twe    = (cmd.clear_step && ((AW + 1)'(clr_cnt) < (AW + 1)'(TILES))) ||
                  cmd.tile_write;
  assign twaddr = cmd.clear_step ? clr_cnt[TAW-1:0] : tile_addr;
  assign twdata = cmd.clear_step ? DEPTH_EMPTY : acc;
  assign depth_rdata = signed'(drd);
  assign tile_rdata  = signed'(trd);

  hzr_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_depth (
    .clk(clk), .we(swe), .waddr(waddr), .wdata(dwdata), .raddr(raddr), .rdata(drd)
  );
  hzr_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_alpha (
    .clk(clk), .we(swe), .waddr(waddr), .wdata(awdata), .raddr(raddr), .rdata(ard)
  );
  hzr_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_beta (
    .clk(clk), .we(swe), .waddr(waddr), .wdata(bwdata), .raddr(raddr), .rdata(brd)
  );
  hzr_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_tri (
    .clk(clk), .we(swe), .waddr(waddr), .wdata(iwdata), .raddr(raddr), .rdata(ird)
  );
  hzr_ram #(.WIDTH(24), .DEPTH(TILES)) u_tile (
    .clk(clk), .we(twe), .waddr(twaddr), .wdata(twdata), .raddr(tile_addr), .rdata(trd)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_draw) begin
      result_kind    <= ACTION_DRAW;
      pixels_written <= count;
      pixel_depth    <= 24'sd0;
      pixel_alpha    <= 16'd0;
      pixel_beta     <= 16'd0;
      pixel_triangle <= 16'd0;
    end else if (cmd.out_read) begin
      result_kind    <= ACTION_READ;
      pixels_written <= 13'd0;
      pixel_depth    <= rp_in_range ? depth_rdata : DEPTH_EMPTY;
      pixel_alpha    <= rp_in_range ? ard : 16'd0;
      pixel_beta     <= rp_in_range ? brd : 16'd0;
      pixel_triangle <= rp_in_range ? ird : 16'd0;
    end
  end

  always_comb begin
    status.clear_done   = clr_cnt == AW'(PIXELS - 1);
    status.bbox_empty   = bb_empty;
    status.tile_skip    = tile_rdata <= minz;
    status.tile_last    = (tx == txhi) && (ty == tyhi);
    status.sub_last     = sub == SUB_LAST;
    status.pix_in_frame = (x_full < (XW + 1)'(FRAME_WIDTH)) &&
                          (y_full < (YW + 1)'(FRAME_HEIGHT));
    status.pix_test     = inbbox && covered;
    status.div_last     = dcnt == DIV_LAST;
    status.z_less       = znew < old_depth;
  end

endmodule

FILE: rtl/hzr_controller.sv
// Controller: sequences clearing, reads, and the tile and pixel walk of a draw.
module hzr_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  output logic             out_valid,
  input  logic             out_stall,
  output hzr_pkg::cmd_t    cmd,
  input  hzr_pkg::status_t status
);
  import hzr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_ISSUE, S_RD_DONE, S_SETUP, S_BOUND, S_T_RD, S_T_CHK,
    S_P_START, S_P_E1, S_P_E2, S_P_COV, S_P_DIV, S_P_ZMUL, S_P_ZSUM, S_P_CMP,
    S_P_NEXT, S_T_WR, S_T_ADV, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (action == ACTION_READ) ? S_RD_ISSUE : S_SETUP;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_sel = 1'b1;
        state_next = S_RD_DONE;
      end
      S_RD_DONE: begin
        cmd.rd_sel = 1'b1;
        if (out_free) begin
          cmd.out_read = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_BOUND;
      end
      S_BOUND: begin
        if (status.bbox_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.tile_start = 1'b1;
          state_next     = S_T_RD;
        end
      end
      S_T_RD: state_next = S_T_CHK;
      S_T_CHK: begin
        if (status.tile_skip) begin
          state_next = S_T_ADV;
        end else begin
          cmd.acc_init = 1'b1;
          cmd.sub_clr  = 1'b1;
          state_next   = S_P_START;
        end
      end
      S_P_START: begin
        if (status.pix_in_frame) begin
          cmd.pix_start = 1'b1;
          state_next    = S_P_E1;
        end else begin
          state_next = S_P_NEXT;
        end
      end
      S_P_E1: begin
        cmd.edge_mul = 1'b1;
        state_next   = S_P_E2;
      end
      S_P_E2: begin
        cmd.edge_sum = 1'b1;
        cmd.old_cap  = 1'b1;
        state_next   = S_P_COV;
      end
      S_P_COV: begin
        if (status.pix_test) begin
          cmd.div_init = 1'b1;
          state_next   = S_P_DIV;
        end else begin
          cmd.acc_old = 1'b1;
          state_next  = S_P_NEXT;
        end
      end
      S_P_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_P_ZMUL;
      end
      S_P_ZMUL: begin
        cmd.z_mul  = 1'b1;
        state_next = S_P_ZSUM;
      end
      S_P_ZSUM: begin
        cmd.z_sum  = 1'b1;
        state_next = S_P_CMP;
      end
      S_P_CMP: begin
        if (status.z_less) begin
          cmd.pix_write = 1'b1;
          cmd.acc_new   = 1'b1;
        end else begin
          cmd.acc_old = 1'b1;
        end
        state_next = S_P_NEXT;
      end
      S_P_NEXT: begin
        if (status.sub_last) begin
          state_next = S_T_WR;
        end else begin
          cmd.sub_inc = 1'b1;
          state_next  = S_P_START;
        end
      end
      S_T_WR: begin
        cmd.tile_write = 1'b1;
        state_next     = S_T_ADV;
      end
      S_T_ADV: begin
        if (status.tile_last) begin
          state_next = S_DONE;
        end else begin
          cmd.tile_adv = 1'b1;
          state_next   = S_T_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_draw = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_draw || cmd.out_read) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/hierarchical_zbuffer_rasterizer_unit.sv
// Top level of the hierarchical z-buffer rasterizer.
//
// Input channel (in_valid / in_stall): one transaction is either a triangle
// to draw or a read of one stored pixel, chosen by action. Output channel
// (out_valid / out_stall): one result transaction for every input one, in
// order. The result sits in an output register, so the next input is taken
// while a result still waits for the receiver.
// A read goes through a read-issue state and then a read-done state, which
// loads its result once the output register is free.
// A draw runs a setup, then visits each 2x2 tile of its bounding box (a tile
// whose stored maximum depth is not above the triangle's least depth is
// skipped after its lookup); each in-frame pixel of a visited tile has its
// edge functions evaluated, and each pixel that the triangle covers also
// passes through the divider for its barycentric weights and the depth
// blend. A new item is not taken until the current one is finished.
// After reset the block runs a clearing pass over all FRAME_WIDTH*FRAME_HEIGHT
// pixel entries (4096 by default) of its stores, and holds in_stall high meanwhile.
// When the receiver stalls, a finished item waits in its final state until
// the output register is free; input is not taken during that wait.
module hierarchical_zbuffer_rasterizer_unit #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [15:0] vertex0_x,
  input  logic signed [15:0] vertex0_y,
  input  logic signed [23:0] vertex0_depth,
  input  logic signed [15:0] vertex1_x,
  input  logic signed [15:0] vertex1_y,
  input  logic signed [23:0] vertex1_depth,
  input  logic signed [15:0] vertex2_x,
  input  logic signed [15:0] vertex2_y,
  input  logic signed [23:0] vertex2_depth,
  input  logic [15:0]        triangle_tag,
  input  logic [11:0]        read_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [12:0]        pixels_written,
  output logic signed [23:0] pixel_depth,
  output logic [15:0]        pixel_alpha,
  output logic [15:0]        pixel_beta,
  output logic [15:0]        pixel_triangle
);
  import hzr_pkg::*;

  cmd_t    cmd;
  status_t status;

  hzr_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  hzr_datapath #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_dp (
    .clk(clk), .rst(rst),
    .vertex0_x(vertex0_x), .vertex0_y(vertex0_y), .vertex0_depth(vertex0_depth),
    .vertex1_x(vertex1_x), .vertex1_y(vertex1_y), .vertex1_depth(vertex1_depth),
    .vertex2_x(vertex2_x), .vertex2_y(vertex2_y), .vertex2_depth(vertex2_depth),
    .triangle_tag(triangle_tag), .read_pixel(read_pixel),
    .cmd(cmd), .status(status),
    .result_kind(result_kind), .pixels_written(pixels_written),
    .pixel_depth(pixel_depth), .pixel_alpha(pixel_alpha), .pixel_beta(pixel_beta),
    .pixel_triangle(pixel_triangle)
  );

endmodule

FILE: test/tb_hierarchical_zbuffer_rasterizer_unit.sv
// Self-checking testbench of the hierarchical z-buffer rasterizer with a flat z-buffer predictor.
`timescale 1ns / 1ps

module tb_hierarchical_zbuffer_rasterizer_unit;
  import hzr_pkg::*;

  localparam int WIDTH  = 64;
  localparam int HEIGHT = 64;
  localparam int PIXELS = WIDTH * HEIGHT;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic               act;
    logic signed [15:0] vx [3];
    logic signed [15:0] vy [3];
    logic signed [23:0] vz [3];
    logic [15:0]        tag;
    logic [11:0]        pix;
    bit                 drain;
  } tri_item_t;

  typedef struct packed {
    logic               kind;
    logic [12:0]        written;
    logic signed [23:0] depth;
    logic [15:0]        alpha;
    logic [15:0]        beta;
    logic [15:0]        tri_id;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic signed [15:0] vertex0_x = '0, vertex0_y = '0, vertex1_x = '0, vertex1_y = '0;
  logic signed [15:0] vertex2_x = '0, vertex2_y = '0;
  logic signed [23:0] vertex0_depth = '0, vertex1_depth = '0, vertex2_depth = '0;
  logic [15:0] triangle_tag = '0;
  logic [11:0] read_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic result_kind;
  logic [12:0] pixels_written;
  logic signed [23:0] pixel_depth;
  logic [15:0] pixel_alpha, pixel_beta, pixel_triangle;

  hierarchical_zbuffer_rasterizer_unit #(.FRAME_WIDTH(WIDTH), .FRAME_HEIGHT(HEIGHT)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .vertex0_x(vertex0_x), .vertex0_y(vertex0_y), .vertex0_depth(vertex0_depth),
    .vertex1_x(vertex1_x), .vertex1_y(vertex1_y), .vertex1_depth(vertex1_depth),
    .vertex2_x(vertex2_x), .vertex2_y(vertex2_y), .vertex2_depth(vertex2_depth),
    .triangle_tag(triangle_tag), .read_pixel(read_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .pixels_written(pixels_written), .pixel_depth(pixel_depth), .pixel_alpha(pixel_alpha),
    .pixel_beta(pixel_beta), .pixel_triangle(pixel_triangle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted frame contents.
  logic signed [23:0] depth_buf [PIXELS];
  logic [15:0] alpha_buf [PIXELS];
  logic [15:0] beta_buf [PIXELS];
  logic [15:0] tag_buf [PIXELS];

  tri_item_t     pending_items [$];
  pixel_result_t expected_pixels [$];
  int mismatches = 0;
  int draws_done = 0, reads_done = 0, pixels_total = 0;

  // Only tiles that cannot be written are culled, so a flat z-buffer gives the same answers.
  function automatic pixel_result_t rasterize(tri_item_t it);
    longint minx, maxx, miny, maxy, px, py, e0, e1, e2, area, a, b, g, z;
    longint x [3], y [3], d [3];
    int idx, cnt;
    pixel_result_t r;
    r = '0;
    if (it.act == ACTION_READ) begin
      r.kind = 1'b1;
      if (it.pix < PIXELS) begin
        r.depth  = depth_buf[it.pix];
        r.alpha  = alpha_buf[it.pix];
        r.beta   = beta_buf[it.pix];
        r.tri_id = tag_buf[it.pix];
      end else begin
        r.depth = DEPTH_EMPTY;
      end
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      x[i] = it.vx[i];
      y[i] = it.vy[i];
      d[i] = it.vz[i];
    end
    minx = x[0]; maxx = x[0]; miny = y[0]; maxy = y[0];
    for (int i = 1; i < 3; i++) begin
      if (x[i] < minx) minx = x[i];
      if (x[i] > maxx) maxx = x[i];
      if (y[i] < miny) miny = y[i];
      if (y[i] > maxy) maxy = y[i];
    end
    cnt = 0;
    for (int row = 0; row < HEIGHT; row++) begin
      if (row * 256 > maxy || (row + 1) * 256 < miny) continue;
      for (int col = 0; col < WIDTH; col++) begin
        if (col * 256 > maxx || (col + 1) * 256 < minx) continue;
        px = col * 256 + 128;
        py = row * 256 + 128;
        e0 = (x[1] - x[2]) * (py - y[2]) - (y[1] - y[2]) * (px - x[2]);
        e1 = (x[2] - x[0]) * (py - y[0]) - (y[2] - y[0]) * (px - x[0]);
        e2 = (x[0] - x[1]) * (py - y[1]) - (y[0] - y[1]) * (px - x[1]);
        if (!((e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0))) continue;
        area = e0 + e1 + e2;
        if (area < 0) begin
          area = -area;
          e0 = -e0;
          e1 = -e1;
        end
        a = (e0 * 65536) / area;
        b = (e1 * 65536) / area;
        g = 65536 - a - b;
        z = (a * d[0] + b * d[1] + g * d[2] + 32768) >>> 16;
        idx = row * WIDTH + col;
        if (z < longint'(depth_buf[idx])) begin
          depth_buf[idx] = z[23:0];
          alpha_buf[idx] = a[15:0];
          beta_buf[idx]  = b[15:0];
          tag_buf[idx]   = it.tag;
          if (cnt < COUNT_MAX) cnt++;
        end
      end
    end
    r.written = cnt[12:0];
    pixels_total += cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Driver: bursts of random length with random gaps.
  int burst_left = 4, gap_left = 0;
  bit stimulus_done = 0;
  always @(posedge clk) begin
    tri_item_t nxt;
    bit hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        nxt.act = action;
        nxt.vx[0] = vertex0_x; nxt.vy[0] = vertex0_y; nxt.vz[0] = vertex0_depth;
        nxt.vx[1] = vertex1_x; nxt.vy[1] = vertex1_y; nxt.vz[1] = vertex1_depth;
        nxt.vx[2] = vertex2_x; nxt.vy[2] = vertex2_y; nxt.vz[2] = vertex2_depth;
        nxt.tag = triangle_tag;
        nxt.pix = read_pixel;
        if (action == ACTION_READ) reads_done++;
        else draws_done++;
        expected_pixels.push_back(rasterize(nxt));
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_pixels.size() > 0)) begin
          nxt = pending_items.pop_front();
          action <= nxt.act;
          vertex0_x <= nxt.vx[0]; vertex0_y <= nxt.vy[0]; vertex0_depth <= nxt.vz[0];
          vertex1_x <= nxt.vx[1]; vertex1_y <= nxt.vy[1]; vertex1_depth <= nxt.vz[1];
          vertex2_x <= nxt.vx[2]; vertex2_y <= nxt.vy[2]; vertex2_depth <= nxt.vz[2];
          triangle_tag <= nxt.tag;
          read_pixel <= nxt.pix;
          in_valid <= 1'b1;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
          if (pending_items.size() == 0) stimulus_done = 1;
        end
      end
    end
  end

  // Monitor: checks every result in order and switches among four stall patterns.
  int stall_cycle = 0;
  always @(posedge clk) begin
    pixel_result_t want;
    int mode;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (result_kind !== want.kind) report_mismatch("result_kind", result_kind, want.kind);
        if (pixels_written !== want.written)
          report_mismatch("pixels_written", pixels_written, want.written);
        if (pixel_depth !== want.depth) report_mismatch("pixel_depth", pixel_depth, want.depth);
        if (pixel_alpha !== want.alpha) report_mismatch("pixel_alpha", pixel_alpha, want.alpha);
        if (pixel_beta !== want.beta) report_mismatch("pixel_beta", pixel_beta, want.beta);
        if (pixel_triangle !== want.tri_id)
          report_mismatch("pixel_triangle", pixel_triangle, want.tri_id);
      end
    end
    stall_cycle++;
    mode = (stall_cycle / 256) % 4;
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_cycle % 32) < 20);
    endcase
  end

  // Watchdog on cycles without any transaction.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic tri_item_t make_read(int unsigned pix);
    tri_item_t it;
    it.act = ACTION_READ;
    for (int i = 0; i < 3; i++) begin
      it.vx[i] = 16'($urandom);
      it.vy[i] = 16'($urandom);
      it.vz[i] = 24'($urandom);
    end
    it.tag = 16'($urandom);
    it.pix = pix[11:0];
    it.drain = 0;
    return it;
  endfunction

  function automatic tri_item_t make_draw(int x0, int y0, int z0, int x1, int y1, int z1,
                                          int x2, int y2, int z2, int tg);
    tri_item_t it;
    it.act = ACTION_DRAW;
    it.vx[0] = 16'(x0); it.vy[0] = 16'(y0); it.vz[0] = 24'(z0);
    it.vx[1] = 16'(x1); it.vy[1] = 16'(y1); it.vz[1] = 24'(z1);
    it.vx[2] = 16'(x2); it.vy[2] = 16'(y2); it.vz[2] = 24'(z2);
    it.tag = 16'(tg);
    it.pix = 12'($urandom);
    it.drain = 0;
    return it;
  endfunction

  // Small random triangle near a random pixel; some snapped to centers, some degenerate.
  function automatic tri_item_t random_draw();
    int cx, cy, span, zb, zr;
    int x [3], y [3], z [3];
    cx = $urandom_range(0, 71) - 4;
    cy = $urandom_range(0, 71) - 4;
    span = $urandom_range(1, 6) * 256;
    zb = $urandom_range(0, 8000) - 4000;
    zr = $urandom_range(0, 3000);
    for (int i = 0; i < 3; i++) begin
      x[i] = cx * 256 + $urandom_range(0, span) - span / 2;
      y[i] = cy * 256 + $urandom_range(0, span) - span / 2;
      if ($urandom_range(0, 5) == 0) begin
        x[i] = (x[i] & ~255) + 128;
        y[i] = (y[i] & ~255) + 128;
      end
      if ($urandom_range(0, 9) == 0) z[i] = $signed(24'($urandom));
      else z[i] = zb + $urandom_range(0, zr);
    end
    if ($urandom_range(0, 19) == 0) begin
      x[2] = 2 * x[1] - x[0];
      y[2] = 2 * y[1] - y[0];
    end
    return make_draw(x[0], y[0], z[0], x[1], y[1], z[1], x[2], y[2], z[2], $urandom);
  endfunction

  initial begin
    tri_item_t it;
    int px, py;
    for (int i = 0; i < PIXELS; i++) begin
      depth_buf[i] = DEPTH_EMPTY;
      alpha_buf[i] = '0;
      beta_buf[i] = '0;
      tag_buf[i] = '0;
    end

    // Directed part.
    pending_items.push_back(make_read(0));
    pending_items.push_back(make_read(4095));
    // Triangle at the coordinate extremes, lowest and highest depths; its box spans the screen.
    pending_items.push_back(make_draw(-32768, -32768, 8388607, 32767, -32768, -8388608,
                                      -32768, 32767, 8388606, 16'hFFFF));
    pending_items.push_back(make_read(0));
    pending_items.push_back(make_read(2080));
    pending_items.push_back(make_read(4095));
    // Small triangle with centers exactly on its edges, drawn twice: equal depth must not write.
    it = make_draw(128, 128, -8388608, 1664, 128, -8388608, 128, 1664, -8388608, 16'h1234);
    pending_items.push_back(it);
    pending_items.push_back(it);
    pending_items.push_back(make_read(0));
    pending_items.push_back(make_read(65));
    // Degenerate: collinear vertices.
    pending_items.push_back(make_draw(256, 256, 0, 1024, 1024, 0, 2048, 2048, 0, 16'h0001));
    // Entirely off screen, near the far corner, and partly off screen.
    pending_items.push_back(make_draw(-2048, -2048, -100, -512, -2048, -100, -2048, -512, -100, 2));
    pending_items.push_back(make_draw(15000, 15000, 5, 16000, 15000, 5, 15000, 16000, 5, 3));
    pending_items.push_back(make_draw(-600, 15000, -9000000 + 700000, 900, 16300, 0,
                                      -700, 16600, 10, 4));
    pending_items.push_back(make_read(63 * 64));
    pending_items.push_back(make_read(62 * 64 + 1));
    // Clockwise winding and a triangle in front of the first one.
    pending_items.push_back(make_draw(2000, 2000, 100, 2000, 3500, -200, 3800, 2600, 40, 16'h8000));
    pending_items.push_back(make_read(9 * 64 + 9));
    it = make_read(10 * 64 + 9);
    it.drain = 1;
    pending_items.push_back(it);

    // Random part: mostly small draws, reads aimed at recently drawn spots.
    for (int n = 0; n < 1080; n++) begin
      if (n % 400 == 399) begin
        it = make_draw(-200, -300, $urandom_range(0, 1000) - 8388000, 16700, 100, 0,
                       300, 16500, -50, $urandom);
        it.drain = 1;
      end else if ($urandom_range(0, 9) < 6) begin
        it = random_draw();
        px = (int'(it.vx[0]) >>> 8) + $urandom_range(0, 2) - 1;
        py = (int'(it.vy[0]) >>> 8) + $urandom_range(0, 2) - 1;
        if (n % 150 == 149) it.drain = 1;
      end else if ($urandom_range(0, 3) != 0 && px >= 0 && px < WIDTH && py >= 0 && py < HEIGHT)
        begin
        it = make_read(py * WIDTH + px);
        px = px + $urandom_range(0, 2) - 1;
      end else begin
        it = make_read($urandom_range(0, 4095));
      end
      pending_items.push_back(it);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!stimulus_done || in_valid) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d draws writing %0d pixels and %0d reads,", draws_done, pixels_total,
             reads_done);
    $display("with edge-centered, degenerate, off-screen and whole-screen triangles.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: hierarchical_zbuffer_rasterizer_unit.f
rtl/hzr_pkg.sv
rtl/hzr_ram.sv
rtl/hzr_datapath.sv
rtl/hzr_controller.sv
rtl/hierarchical_zbuffer_rasterizer_unit.sv
test/tb_hierarchical_zbuffer_rasterizer_unit.sv
